@@ rtl/core/sfm_pkg.sv @@
package sfm_pkg;

  // Field widths of the stream items and the configuration registers
  localparam int ACT_W   = 2;
  localparam int NAME_W  = 64;
  localparam int DATA_W  = 64;
  localparam int SIZE_W  = 4;
  localparam int STAT_W  = 3;
  localparam int PTR_W   = 9;
  localparam int FNUM_W  = 3;
  localparam int HDR_W   = 6;
  localparam int MAXB_W  = 8;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 5;
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 96;

  localparam int DEF_MAX_FRAMES = 5;
  localparam int DEF_ADDR_BITS  = 9;

  localparam logic [PTR_W-1:0]  RST_HEAP_LIMIT  = 9'd0;
  localparam logic [PTR_W-1:0]  RST_STACK_FLOOR = 9'd199;
  localparam logic [PTR_W-1:0]  RST_STACK_BASE  = 9'd394;
  localparam logic [HDR_W-1:0]  RST_HDR_BYTES   = 6'd10;
  localparam logic [MAXB_W-1:0] RST_MAX_BYTES   = 8'd80;

  localparam logic [SIZE_W-1:0] MAX_PUSH_BYTES = 4'd8;

  typedef enum logic [ACT_W-1:0] {
    ACT_CREATE = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_PUSH   = 2'd2
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_NAME   = 3'd1,
    ST_OVERFLOW   = 3'd2,
    ST_DUPLICATE  = 3'd3,
    ST_NO_SLOT    = 3'd4,
    ST_EMPTY      = 3'd5,
    ST_FRAME_FULL = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    REG_HEAP_LIMIT  = 3'd0,
    REG_STACK_FLOOR = 3'd1,
    REG_STACK_BASE  = 3'd2,
    REG_HDR_BYTES   = 3'd3,
    REG_MAX_BYTES   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [PTR_W-1:0]  heap_limit;
    logic [PTR_W-1:0]  stack_floor;
    logic [PTR_W-1:0]  stack_base;
    logic [HDR_W-1:0]  hdr_bytes;
    logic [MAXB_W-1:0] max_bytes;
  } cfg_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [NAME_W-1:0] item_name;
    logic [DATA_W-1:0] data_value;
    logic [SIZE_W-1:0] data_bytes;
  } item_t;

  typedef struct packed {
    logic [SIZE_W-1:0] write_bytes;
    logic [DATA_W-1:0] write_data;
    logic [PTR_W-1:0]  write_address;
    logic              write_enable;
    logic [FNUM_W-1:0] frame_number;
    logic [PTR_W-1:0]  stack_pointer;
    logic [STAT_W-1:0] status;
  } result_t;

endpackage

@@ rtl/core/sfm_cfg.sv @@
module sfm_cfg import sfm_pkg::*; #(
  parameter int ADDR_BITS = DEF_ADDR_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o,
  output logic              base_wr_o,
  output logic [PTR_W-1:0]  base_val_o
);

  localparam logic [PTR_W-1:0] CfgMask =
      (ADDR_BITS >= PTR_W) ? {PTR_W{1'b1}} : PTR_W'((1 << ADDR_BITS) - 1);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign wr_idx = reg_idx_e'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.heap_limit  <= RST_HEAP_LIMIT & CfgMask;
      cfg_q.stack_floor <= RST_STACK_FLOOR;
      cfg_q.stack_base  <= RST_STACK_BASE & CfgMask;
      cfg_q.hdr_bytes   <= RST_HDR_BYTES;
      cfg_q.max_bytes   <= RST_MAX_BYTES;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_HEAP_LIMIT:  cfg_q.heap_limit  <= pwdata[PTR_W-1:0] & CfgMask;
        REG_STACK_FLOOR: cfg_q.stack_floor <= pwdata[PTR_W-1:0] & CfgMask;
        REG_STACK_BASE:  cfg_q.stack_base  <= pwdata[PTR_W-1:0] & CfgMask;
        REG_HDR_BYTES:   cfg_q.hdr_bytes   <= pwdata[HDR_W-1:0];
        REG_MAX_BYTES:   cfg_q.max_bytes   <= pwdata[MAXB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (wr_idx)
      REG_HEAP_LIMIT:  prdata = APB_DW'(cfg_q.heap_limit);
      REG_STACK_FLOOR: prdata = APB_DW'(cfg_q.stack_floor);
      REG_STACK_BASE:  prdata = APB_DW'(cfg_q.stack_base);
      REG_HDR_BYTES:   prdata = APB_DW'(cfg_q.hdr_bytes);
      REG_MAX_BYTES:   prdata = APB_DW'(cfg_q.max_bytes);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o      = cfg_q;
  assign base_wr_o  = wr_en && (wr_idx == REG_STACK_BASE);
  // The new base is taken from the bus, as the register itself only
  // changes at the same edge.
  assign base_val_o = pwdata[PTR_W-1:0] & CfgMask;

endmodule

@@ rtl/core/sfm_table.sv @@
module sfm_table import sfm_pkg::*; #(
  parameter int MAX_FRAMES = DEF_MAX_FRAMES,
  parameter int ADDR_BITS  = DEF_ADDR_BITS,
  parameter int CNT_W      = $clog2(MAX_FRAMES + 1),
  parameter int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [IDX_W-1:0]     wr_idx_i,
  input  logic [NAME_W-1:0]    wr_name_i,
  input  logic [ADDR_BITS-1:0] wr_base_i,
  input  logic [CNT_W-1:0]     count_i,
  input  logic [NAME_W-1:0]    cmp_name_i,
  output logic                 dup_o,
  output logic [ADDR_BITS-1:0] top_base_o
);

  logic [NAME_W-1:0]    names_q [MAX_FRAMES];
  logic [ADDR_BITS-1:0] bases_q [MAX_FRAMES];
  logic [IDX_W-1:0]     top_idx;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      names_q[wr_idx_i] <= wr_name_i;
      bases_q[wr_idx_i] <= wr_base_i;
    end
  end

  // Only slots below the frame count are live; names left in freed slots
  // take no part in the duplicate check.
  always_comb begin
    dup_o = 1'b0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if ((CNT_W'(i) < count_i) && (names_q[i] == cmp_name_i)) begin
        dup_o = 1'b1;
      end
    end
  end

  assign top_idx    = IDX_W'(count_i - CNT_W'(1));
  assign top_base_o = bases_q[top_idx];

endmodule

@@ rtl/core/sfm_step.sv @@
module sfm_step import sfm_pkg::*; #(
  parameter int MAX_FRAMES = DEF_MAX_FRAMES,
  parameter int ADDR_BITS  = DEF_ADDR_BITS,
  parameter int CNT_W      = $clog2(MAX_FRAMES + 1)
) (
  input  item_t                item_i,
  input  cfg_t                 cfg_i,
  input  logic [ADDR_BITS-1:0] tos_i,
  input  logic [CNT_W-1:0]     count_i,
  input  logic                 dup_i,
  input  logic [ADDR_BITS-1:0] top_base_i,
  output logic [ADDR_BITS-1:0] tos_o,
  output logic [CNT_W-1:0]     count_o,
  output logic                 tbl_wr_o,
  output result_t              res_o
);

  localparam int AW = ADDR_BITS;
  localparam int CW = ((AW > PTR_W) ? AW : PTR_W) + 1;
  localparam int UW = ((AW > MAXB_W) ? AW : MAXB_W) + 2;

  logic [SIZE_W-1:0] size_c;
  logic [HDR_W-1:0]  chk_size;
  logic [CW-1:0]     next_ptr;
  logic              collides;
  logic              frame_full;
  logic              name_empty;
  logic [DATA_W-1:0] data_masked;

  always_comb begin
    if (item_i.data_bytes > MAX_PUSH_BYTES) begin
      size_c = MAX_PUSH_BYTES;
    end else if (item_i.data_bytes == '0) begin
      size_c = SIZE_W'(1);
    end else begin
      size_c = item_i.data_bytes;
    end
  end

  // The top bit of the difference is the borrow: a pointer below zero is
  // always under the floor.
  assign chk_size = (item_i.action == ACT_CREATE) ? cfg_i.hdr_bytes : HDR_W'(size_c);
  assign next_ptr = CW'(tos_i) - CW'(chk_size);
  assign collides = next_ptr[CW-1] || (next_ptr < CW'(cfg_i.stack_floor)) ||
                    (next_ptr <= CW'(cfg_i.heap_limit));

  assign frame_full = (UW'(top_base_i) + UW'(size_c)) > (UW'(tos_i) + UW'(cfg_i.max_bytes));
  assign name_empty = (item_i.item_name == '0);

  always_comb begin
    for (int b = 0; b < DATA_W / 8; b++) begin
      data_masked[b*8 +: 8] = (SIZE_W'(b) < size_c) ? item_i.data_value[b*8 +: 8] : 8'h00;
    end
  end

  always_comb begin
    status_e st;
    st       = ST_OK;
    tos_o    = tos_i;
    count_o  = count_i;
    tbl_wr_o = 1'b0;
    res_o    = '0;
    unique case (item_i.action)
      ACT_CREATE: begin
        if (name_empty) begin
          st = ST_BAD_NAME;
        end else if (collides) begin
          st = ST_OVERFLOW;
        end else if (dup_i) begin
          st = ST_DUPLICATE;
        end else if (count_i >= CNT_W'(MAX_FRAMES)) begin
          st = ST_NO_SLOT;
        end else begin
          tbl_wr_o           = 1'b1;
          count_o            = count_i + CNT_W'(1);
          res_o.frame_number = FNUM_W'(count_i + CNT_W'(1));
          tos_o              = tos_i - AW'(cfg_i.hdr_bytes);
        end
      end
      ACT_DELETE: begin
        if ((tos_i == AW'(cfg_i.stack_base)) || (count_i == '0)) begin
          st = ST_EMPTY;
        end else begin
          count_o = count_i - CNT_W'(1);
          tos_o   = top_base_i;
        end
      end
      ACT_PUSH: begin
        if (name_empty) begin
          st = ST_BAD_NAME;
        end else if (collides) begin
          st = ST_OVERFLOW;
        end else if (count_i == '0) begin
          st = ST_EMPTY;
        end else if (frame_full) begin
          st = ST_FRAME_FULL;
        end else begin
          res_o.write_enable  = 1'b1;
          res_o.write_address = PTR_W'(tos_i);
          res_o.write_bytes   = size_c;
          res_o.write_data    = data_masked;
          tos_o               = tos_i - AW'(size_c);
        end
      end
      default: ;
    endcase
    res_o.status        = st;
    res_o.stack_pointer = PTR_W'(tos_o);
  end

endmodule

@@ rtl/core/stack_frame_manager.sv @@
// Stack frame manager: a downward-growing call stack with a small frame table.
// Input items arrive on the s_axis channel (tuser carries the action: create
// a frame, delete the top frame or push a value); every item produces exactly
// one result item on the m_axis channel with a status, the new stack pointer,
// the number of a newly created frame and, for an accepted push, one
// little-endian memory write (address, data, byte count).
// Registers are to be written through the APB port only while no item is in
// flight; the block itself does not enforce this. Writing the stack base also
// moves the stack pointer when no frame exists and no item is being processed.
// An input register and a result register bracket a single combinational step
// that reads and updates the pointer, frame count and frame table, so one item
// is taken per cycle while the receiver takes results. A stalled receiver
// holds the result register; the input register still takes one more item,
// after which s_axis_tready_o falls until the result is taken.
// Reset empties both registers, clears the frame count and loads the stack
// pointer with the reset stack base; frame table entries need no reset.
module stack_frame_manager import sfm_pkg::*; #(
  parameter int MAX_FRAMES = DEF_MAX_FRAMES,
  parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // item_name [63:0], data_value [127:64], data_bytes [131:128], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // action [1:0]
  input  logic [ACT_W-1:0]       s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // status [2:0], stack_pointer [11:3], frame_number [14:12],
  // write_enable [15], write_address [24:16], write_data [88:25],
  // write_bytes [92:89], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int AW    = ADDR_BITS;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam logic [AW-1:0] TosRst = AW'(RST_STACK_BASE);

  cfg_t             cfg;
  logic             base_wr;
  logic [PTR_W-1:0] base_val;
  logic             in_valid_q;
  item_t            item_q;
  logic             out_valid_q;
  result_t          res_q;
  logic             advance;
  logic [AW-1:0]    tos_q, tos_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             tbl_wr;
  logic             dup;
  logic [AW-1:0]    top_base;
  result_t          res_d;

  sfm_cfg #(
    .ADDR_BITS(ADDR_BITS)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .base_wr_o (base_wr),
    .base_val_o(base_val)
  );

  sfm_table #(
    .MAX_FRAMES(MAX_FRAMES),
    .ADDR_BITS (ADDR_BITS),
    .CNT_W     (CNT_W),
    .IDX_W     (IDX_W)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (advance && tbl_wr),
    .wr_idx_i  (IDX_W'(count_q)),
    .wr_name_i (item_q.item_name),
    .wr_base_i (tos_q),
    .count_i   (count_q),
    .cmp_name_i(item_q.item_name),
    .dup_o     (dup),
    .top_base_o(top_base)
  );

  sfm_step #(
    .MAX_FRAMES(MAX_FRAMES),
    .ADDR_BITS (ADDR_BITS),
    .CNT_W     (CNT_W)
  ) u_step (
    .item_i    (item_q),
    .cfg_i     (cfg),
    .tos_i     (tos_q),
    .count_i   (count_q),
    .dup_i     (dup),
    .top_base_i(top_base),
    .tos_o     (tos_d),
    .count_o   (count_d),
    .tbl_wr_o  (tbl_wr),
    .res_o     (res_d)
  );

  // The held item is processed when the result register is free or is
  // being emptied in the same cycle.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      item_q.action     <= s_axis_tuser_i;
      item_q.item_name  <= s_axis_tdata_i[NAME_W-1:0];
      item_q.data_value <= s_axis_tdata_i[NAME_W +: DATA_W];
      item_q.data_bytes <= s_axis_tdata_i[NAME_W+DATA_W +: SIZE_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tos_q   <= TosRst;
      count_q <= '0;
    end else if (advance) begin
      tos_q   <= tos_d;
      count_q <= count_d;
    end else if (base_wr && (count_q == '0)) begin
      tos_q <= AW'(base_val);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(res_q);

endmodule
